### rtl/core/gmwt_pkg.sv
`timescale 1ns / 1ps
// gmwt_pkg: request and response words, codes and sequencer states
// for the grid maze wall toggle core; no dependencies

package gmwt_pkg;

  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  localparam int ROOM_W = 8;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ROOM_W-1:0] room;
    logic [1:0]        direction;
  } gmwt_req_t;

  typedef struct packed {
    logic outcome;
    logic rejected;
  } gmwt_rsp_t;

  // door word per room: bit 0 right door, bit 1 down door
  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_mask;
    logic [1:0] wr_data;
  } gmwt_mem_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_COL,
    ST_CHECK,
    ST_EVAL,
    ST_WADDR,
    ST_WSTEP
  } gmwt_state_t;

endpackage

### rtl/core/gmwt_door_ram.sv
`timescale 1ns / 1ps
// gmwt_door_ram: door memory, one 2-bit word per room, masked write,
// registered read; depends on gmwt_pkg

module gmwt_door_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                   clk,
  input  gmwt_pkg::gmwt_mem_ctl_t ctl,
  input  logic [AW-1:0]          wr_addr,
  input  logic [AW-1:0]          rd_addr,
  output logic [1:0]             rd_data
);
  import gmwt_pkg::*;

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      if (ctl.wr_mask[0]) begin
        mem[wr_addr][0] <= ctl.wr_data[0];
      end
      if (ctl.wr_mask[1]) begin
        mem[wr_addr][1] <= ctl.wr_data[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/grid_maze_wall_toggle_core.sv
`timescale 1ns / 1ps
// grid_maze_wall_toggle_core: top level, request sequencer with a shared
// door lookup and walker step unit; depends on gmwt_pkg and gmwt_door_ram
//
// usage
//   a request word (operation, room, direction) is taken on a clock edge
//   with start high and busy low. busy stays high until the response word
//   is shown on rsp with done high for exactly one cycle; the receiver
//   cannot hold it off, and busy is low again in that same cycle.
//   open and query raise done from the eval state, after the div, col
//   and check states (from the check state for a rejected request or a
//   query left or up off the grid). a close that finds a door runs the
//   wall walk through the shared lookup unit, a waddr and a wstep state
//   per walk step (one door memory read each), at most 4*N+4 steps for
//   N = GRID_SIDE*GRID_SIDE rooms. the door memory read port sets the
//   walk rate. after reset the door memory is swept to its initial pattern
//   (doors everywhere but the right and bottom edges), one room per
//   cycle, with busy high; no request is taken during the sweep.

module grid_maze_wall_toggle_core #(
  parameter int GRID_SIDE = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  gmwt_pkg::gmwt_req_t req,
  output logic               done,
  output gmwt_pkg::gmwt_rsp_t rsp
);
  import gmwt_pkg::*;

  localparam int NUM_ROOMS  = GRID_SIDE * GRID_SIDE;
  localparam int IW         = $clog2(NUM_ROOMS);
  localparam int CW         = $clog2(GRID_SIDE);
  localparam int WALK_LIMIT = 4 * NUM_ROOMS + 4;
  localparam int SW         = $clog2(WALK_LIMIT + 1);
  localparam int DIV_SHIFT  = 16;
  localparam int DIV_MUL    = ((1 << DIV_SHIFT) + GRID_SIDE - 1) / GRID_SIDE;

  gmwt_state_t state, state_next;
  gmwt_req_t   req_q, req_q_next;
  gmwt_rsp_t   rsp_next;
  logic        done_next;

  logic [ROOM_W-1:0] quot, quot_next;
  logic [IW-1:0]     pos_idx, pos_idx_next;
  logic [CW-1:0]     pos_col, pos_col_next;
  logic [1:0]        head, head_next;
  logic [IW-1:0]     start_idx, start_idx_next;
  logic [IW-1:0]     target, target_next;
  logic [SW-1:0]     steps, steps_next;
  logic              border_q, border_q_next;

  gmwt_mem_ctl_t mem_ctl;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] look_addr;
  logic [1:0]    rd_data;

  logic          border;
  logic          door_bit;
  logic [IW-1:0] mv_idx;
  logic [CW-1:0] mv_col;
  logic          in_grid;
  logic          edge_rej;
  logic          reached;
  logic          back_home;

  gmwt_door_ram #(
    .DEPTH(NUM_ROOMS),
    .AW   (IW)
  ) u_ram (
    .clk    (clk),
    .ctl    (mem_ctl),
    .wr_addr(wr_addr),
    .rd_addr(look_addr),
    .rd_data(rd_data)
  );

  assign wr_addr = (state == ST_CLEAR) ? pos_idx : start_idx;
  assign busy    = (state != ST_IDLE);

  // shared lookup and move unit
  always_comb begin
    border = ((head == DIR_LEFT) && (pos_col == '0)) ||
             ((head == DIR_UP) && (pos_idx < IW'(GRID_SIDE)));
    door_bit = head[0] ? rd_data[1] : rd_data[0];
    case (head)
      DIR_RIGHT: begin
        look_addr = pos_idx;
        mv_idx    = pos_idx + IW'(1);
        mv_col    = pos_col + CW'(1);
      end
      DIR_DOWN: begin
        look_addr = pos_idx;
        mv_idx    = pos_idx + IW'(GRID_SIDE);
        mv_col    = pos_col;
      end
      DIR_LEFT: begin
        look_addr = pos_idx - IW'(1);
        mv_idx    = pos_idx - IW'(1);
        mv_col    = pos_col - CW'(1);
      end
      default: begin
        look_addr = pos_idx - IW'(GRID_SIDE);
        mv_idx    = pos_idx - IW'(GRID_SIDE);
        mv_col    = pos_col;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    req_q_next     = req_q;
    rsp_next       = rsp;
    done_next      = 1'b0;
    quot_next      = quot;
    pos_idx_next   = pos_idx;
    pos_col_next   = pos_col;
    head_next      = head;
    start_idx_next = start_idx;
    target_next    = target;
    steps_next     = steps;
    border_q_next  = border_q;
    mem_ctl        = '0;
    in_grid        = (32'(req_q.room) < NUM_ROOMS);
    edge_rej       = (req_q.direction == DIR_LEFT) || (req_q.direction == DIR_UP) ||
                     ((req_q.direction == DIR_RIGHT) && (pos_col == CW'(GRID_SIDE - 1))) ||
                     ((req_q.direction == DIR_DOWN) &&
                      (pos_idx >= IW'(NUM_ROOMS - GRID_SIDE)));
    reached        = 1'b0;
    back_home      = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        mem_ctl.wr_en      = 1'b1;
        mem_ctl.wr_mask    = 2'b11;
        mem_ctl.wr_data[0] = (pos_col != CW'(GRID_SIDE - 1));
        mem_ctl.wr_data[1] = (pos_idx < IW'(NUM_ROOMS - GRID_SIDE));
        pos_idx_next = pos_idx + IW'(1);
        pos_col_next = (pos_col == CW'(GRID_SIDE - 1)) ? '0 : pos_col + CW'(1);
        if (pos_idx == IW'(NUM_ROOMS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_q_next = req;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        quot_next  = ROOM_W'((32'(req_q.room) * DIV_MUL) >> DIV_SHIFT);
        state_next = ST_COL;
      end
      ST_COL: begin
        pos_col_next   = CW'(32'(req_q.room) - 32'(quot) * GRID_SIDE);
        pos_idx_next   = IW'(req_q.room);
        start_idx_next = IW'(req_q.room);
        head_next      = req_q.direction;
        state_next     = ST_CHECK;
      end
      ST_CHECK: begin
        if (!in_grid || (req_q.operation == OP_NONE)) begin
          rsp_next   = '{outcome: 1'b0, rejected: 1'b1};
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (req_q.operation == OP_QUERY) begin
          if (border) begin
            rsp_next   = '{outcome: 1'b0, rejected: 1'b0};
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EVAL;
          end
        end else if (edge_rej) begin
          rsp_next   = '{outcome: 1'b0, rejected: 1'b1};
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        mem_ctl.wr_mask = head[0] ? 2'b10 : 2'b01;
        target_next     = head[0] ? pos_idx + IW'(GRID_SIDE) : pos_idx + IW'(1);
        steps_next      = '0;
        state_next      = ST_IDLE;
        done_next       = 1'b1;
        case (req_q.operation)
          OP_QUERY: begin
            rsp_next = '{outcome: door_bit, rejected: 1'b0};
          end
          OP_OPEN: begin
            mem_ctl.wr_en   = !door_bit;
            mem_ctl.wr_data = 2'b11;
            rsp_next        = '{outcome: !door_bit, rejected: 1'b0};
          end
          default: begin
            if (!door_bit) begin
              rsp_next = '{outcome: 1'b1, rejected: 1'b0};
            end else begin
              mem_ctl.wr_en   = 1'b1;
              mem_ctl.wr_data = 2'b00;
              head_next       = head + 2'd1;
              done_next       = 1'b0;
              state_next      = ST_WADDR;
            end
          end
        endcase
      end
      ST_WADDR: begin
        border_q_next = border;
        state_next    = ST_WSTEP;
      end
      ST_WSTEP: begin
        steps_next = steps + SW'(1);
        if (!border_q && door_bit) begin
          pos_idx_next = mv_idx;
          pos_col_next = mv_col;
          head_next    = head - 2'd1;
        end else begin
          head_next = head + 2'd1;
        end
        reached   = (pos_idx_next == target);
        back_home = (pos_idx_next == start_idx) && (head_next == req_q.direction);
        if (reached) begin
          rsp_next   = '{outcome: 1'b1, rejected: 1'b0};
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (back_home || (steps_next == SW'(WALK_LIMIT))) begin
          mem_ctl.wr_en   = 1'b1;
          mem_ctl.wr_mask = req_q.direction[0] ? 2'b10 : 2'b01;
          mem_ctl.wr_data = 2'b11;
          rsp_next        = '{outcome: 1'b0, rejected: 1'b0};
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_WADDR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      done    <= 1'b0;
      pos_idx <= '0;
      pos_col <= '0;
      head    <= '0;
      steps   <= '0;
    end else begin
      state   <= state_next;
      done    <= done_next;
      pos_idx <= pos_idx_next;
      pos_col <= pos_col_next;
      head    <= head_next;
      steps   <= steps_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q     <= req_q_next;
    rsp       <= rsp_next;
    quot      <= quot_next;
    start_idx <= start_idx_next;
    target    <= target_next;
    border_q  <= border_q_next;
  end

  a_rej_no_outcome: assert property (@(posedge clk) disable iff (rst)
    done && rsp.rejected |-> !rsp.outcome)
    else $error("rejected response carries an outcome");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two responses in a row");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("response shown while still busy");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WSTEP) |-> (steps < SW'(WALK_LIMIT)))
    else $error("walk ran past its step limit");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> (state == ST_CLEAR) || (state == ST_EVAL) || (state == ST_WSTEP))
    else $error("door memory written outside clear, eval or walk");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for grid_maze_wall_toggle_core; keeps its own door grid,
// predicts every response word and checks it; depends on gmwt_pkg and the core rtl

module testbench;
  import gmwt_pkg::*;

  localparam int SIDE       = 16;
  localparam int ROOMS      = SIDE * SIDE;
  localparam int WALK_LIMIT = 4 * ROOMS + 4;
  localparam int RAND_WORDS = 580;

  typedef struct {
    gmwt_req_t word;
    int        gap;
  } queued_word_t;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  gmwt_req_t req   = '0;
  logic      busy;
  logic      done;
  gmwt_rsp_t rsp;

  queued_word_t word_queue[$];
  queued_word_t next_word;
  gmwt_rsp_t    rsp_due[$];
  bit           have_word = 1'b0;
  int           gap_left = 0;
  int           calm_left = 0;
  logic         word_taken = 1'b0;
  int           words_taken = 0;
  int           word_total = 0;
  int           fails = 0;

  bit         right_door [ROOMS];
  bit         down_door [ROOMS];
  logic [7:0] walker_room = '0;
  logic [1:0] walker_heading = '0;

  grid_maze_wall_toggle_core #(.GRID_SIDE(SIDE)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  function automatic bit door_open(int r, logic [1:0] h);
    if (r >= ROOMS) return 1'b0;
    case (h)
      DIR_RIGHT: return right_door[r];
      DIR_DOWN:  return down_door[r];
      DIR_LEFT:  return (r % SIDE == 0) ? 1'b0 : right_door[r-1];
      default:   return (r < SIDE) ? 1'b0 : down_door[r-SIDE];
    endcase
  endfunction

  function automatic int room_beyond(int r, logic [1:0] h);
    case (h)
      DIR_RIGHT: return r + 1;
      DIR_DOWN:  return r + SIDE;
      DIR_LEFT:  return r - 1;
      default:   return r - SIDE;
    endcase
  endfunction

  function automatic void put_door(int r, logic [1:0] d, bit v);
    if (d == DIR_DOWN) down_door[r] = v;
    else right_door[r] = v;
  endfunction

  // clear the door, follow the walls; the wall stays only if the far room is reached
  function automatic bit wall_walk_keeps(int r, logic [1:0] d);
    int         pos = r;
    logic [1:0] head = d + 2'd1;
    int         target = room_beyond(r, d);
    int         steps = 0;
    bit         reached = 1'b0;
    put_door(r, d, 1'b0);
    while (1'b1) begin
      if (door_open(pos, head)) begin
        pos = room_beyond(pos, head);
        head = head + 2'd3;
      end else begin
        head = head + 2'd1;
      end
      steps++;
      if (pos == target) begin
        reached = 1'b1;
        break;
      end
      if (pos == r && head == d) break;
      if (steps >= WALK_LIMIT) break;
    end
    walker_room = pos[7:0];
    walker_heading = head;
    if (!reached) put_door(r, d, 1'b1);
    return reached;
  endfunction

  function automatic gmwt_rsp_t predict_rsp(gmwt_req_t w);
    gmwt_rsp_t  res = '0;
    int         r = int'(w.room);
    logic [1:0] d = w.direction;
    if (w.operation == OP_NONE || r >= ROOMS) begin
      res.rejected = 1'b1;
    end else if (w.operation == OP_QUERY) begin
      res.outcome = door_open(r, d);
    end else if (d == DIR_LEFT || d == DIR_UP ||
                 (d == DIR_RIGHT && r % SIDE == SIDE - 1) ||
                 (d == DIR_DOWN && r >= ROOMS - SIDE)) begin
      res.rejected = 1'b1;
    end else if (w.operation == OP_OPEN) begin
      if (!door_open(r, d)) begin
        put_door(r, d, 1'b1);
        res.outcome = 1'b1;
      end
    end else if (!door_open(r, d)) begin
      res.outcome = 1'b1;
    end else begin
      res.outcome = wall_walk_keeps(r, d);
    end
    return res;
  endfunction

  function automatic void enqueue_word(logic [1:0] op, int room, logic [1:0] dir);
    queued_word_t q;
    q.word.operation = op;
    q.word.room = room[7:0];
    q.word.direction = dir;
    // occasional stretches with no idle cycles at all
    if (calm_left == 0 && $urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 30);
    if (calm_left > 0) begin
      q.gap = 0;
      calm_left--;
    end else begin
      q.gap = $urandom_range(0, 12);
    end
    word_queue.push_back(q);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && word_taken) have_word = 1'b0;
      if (!start || word_taken) begin
        if (!have_word && word_queue.size() != 0) begin
          next_word = word_queue.pop_front();
          have_word = 1'b1;
          gap_left = next_word.gap;
        end
        if (have_word && gap_left == 0) begin
          start <= 1'b1;
          req <= next_word.word;
        end else begin
          start <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    gmwt_rsp_t want;
    word_taken <= !rst && start && !busy;
    if (!rst && done) begin
      if (rsp_due.size() == 0) begin
        $error("unexpected response word: outcome %0b rejected %0b", rsp.outcome, rsp.rejected);
        fails++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp.outcome !== want.outcome) begin
          $error("outcome mismatch: expected %0b, got %0b", want.outcome, rsp.outcome);
          fails++;
        end
        if (rsp.rejected !== want.rejected) begin
          $error("rejected mismatch: expected %0b, got %0b", want.rejected, rsp.rejected);
          fails++;
        end
      end
    end
    if (!rst && start && !busy) begin
      rsp_due.push_back(predict_rsp(req));
      words_taken++;
    end
  end

  initial begin
    int sel;
    int rm;
    for (int i = 0; i < ROOMS; i++) begin
      right_door[i] = (i % SIDE != SIDE - 1);
      down_door[i] = (i < ROOMS - SIDE);
    end

    // directed words
    enqueue_word(OP_QUERY, 0, DIR_RIGHT);
    enqueue_word(OP_QUERY, 0, DIR_DOWN);
    enqueue_word(OP_QUERY, 0, DIR_LEFT);
    enqueue_word(OP_QUERY, 0, DIR_UP);
    enqueue_word(OP_QUERY, 255, DIR_RIGHT);
    enqueue_word(OP_QUERY, 255, DIR_DOWN);
    enqueue_word(OP_OPEN, 0, DIR_RIGHT);
    enqueue_word(OP_CLOSE, 0, DIR_RIGHT);
    enqueue_word(OP_CLOSE, 0, DIR_RIGHT);
    enqueue_word(OP_QUERY, 1, DIR_LEFT);
    enqueue_word(OP_CLOSE, 0, DIR_DOWN);
    enqueue_word(OP_OPEN, 0, DIR_RIGHT);
    enqueue_word(OP_OPEN, SIDE - 1, DIR_RIGHT);
    enqueue_word(OP_CLOSE, ROOMS - SIDE, DIR_DOWN);
    enqueue_word(OP_OPEN, 255, DIR_DOWN);
    enqueue_word(OP_OPEN, 17, DIR_LEFT);
    enqueue_word(OP_CLOSE, 17, DIR_UP);
    enqueue_word(OP_NONE, 0, DIR_RIGHT);
    enqueue_word(OP_NONE, 255, DIR_UP);
    enqueue_word(OP_CLOSE, 254, DIR_RIGHT);
    enqueue_word(OP_QUERY, 255, DIR_LEFT);
    enqueue_word(OP_QUERY, 255, DIR_UP);
    enqueue_word(OP_CLOSE, 239, DIR_DOWN);
    enqueue_word(OP_OPEN, 254, DIR_RIGHT);

    // random words, mostly well formed
    for (int i = 0; i < RAND_WORDS; i++) begin
      sel = $urandom_range(0, 99);
      rm = $urandom_range(0, 255);
      if (sel < 36) enqueue_word(OP_CLOSE, rm, 2'($urandom_range(0, 1)));
      else if (sel < 66) enqueue_word(OP_OPEN, rm, 2'($urandom_range(0, 1)));
      else if (sel < 90) enqueue_word(OP_QUERY, rm, 2'($urandom_range(0, 3)));
      else enqueue_word(2'($urandom_range(0, 3)), rm, 2'($urandom_range(0, 3)));
    end
    word_total = word_queue.size();

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (words_taken != word_total || rsp_due.size() != 0) @(negedge clk);
    repeat (2 * WALK_LIMIT + 16) @(negedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

endmodule
